>>> hw/rtl/mct_pkg.sv
// Shared types and constants for the multichannel compare timer.
package mct_pkg;

	localparam int unsigned USER_CHANNELS = 4;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned MASK_W = 8;

	typedef enum logic [2:0] {
		REQ_TICK      = 3'd0,
		REQ_PERIODIC  = 3'd1,
		REQ_ONESHOT   = 3'd2,
		REQ_REF_PLUS  = 3'd3,
		REQ_REF_MINUS = 3'd4,
		REQ_ADJUST    = 3'd5,
		REQ_CANCEL    = 3'd6,
		REQ_DELAY     = 3'd7
	} req_type_t;

	// Broadcast from the command decoder to every compare channel.
	typedef struct packed {
		logic              go;
		logic              tick;
		logic              arm;
		logic              oneshot;
		logic              adjust;
		logic              cancel;
		logic [TIME_W-1:0] now_next;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] compare;
		logic [TIME_W-1:0] adj;
	} chan_cmd_t;

endpackage

>>> hw/rtl/mct_chan.sv
// One user compare channel: compare, period, one-shot and armed state.
module mct_chan (
	input  logic              clk,
	input  logic              arst_n,
	input  mct_pkg::chan_cmd_t cmd,
	input  logic              sel,
	output logic              fire
);

	logic [mct_pkg::TIME_W-1:0] compare_q;
	logic [mct_pkg::TIME_W-1:0] period_q;
	logic                       oneshot_q;
	logic                       armed_q;

	assign fire = cmd.go && cmd.tick && armed_q && (compare_q == cmd.now_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_q <= '0;
			period_q  <= '0;
			oneshot_q <= 1'b0;
			armed_q   <= 1'b0;
		end else if (fire) begin
			if (oneshot_q) begin
				armed_q <= 1'b0;
			end else begin
				compare_q <= compare_q + period_q;
			end
		end else if (cmd.go && sel) begin
			if (cmd.arm) begin
				compare_q <= cmd.compare;
				period_q  <= cmd.period;
				oneshot_q <= cmd.oneshot;
				armed_q   <= 1'b1;
			end else if (cmd.adjust) begin
				compare_q <= compare_q + cmd.adj;
			end else if (cmd.cancel) begin
				compare_q <= '0;
				period_q  <= '0;
				armed_q   <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/multichannel_compare_timer.sv
// Top level of the multichannel compare timer: input register, decoder, counter and result.
// The timer takes one word per clock cycle while in_stall is low and gives one result word for
// each. The input register holds the accepted word; the update then applies it to the counter,
// the delay compare and all compare channels at once and registers the result. The update waits
// while a full result register is stalled. A tick word advances the 32-bit counter by one;
// command words leave the counter alone. Throughput is one word per cycle while nothing stalls,
// set by the single update stage; input stall rises only while the input register holds a word
// and the result register is full and stalled. Channel commands that address a channel not below
// the channel count are ignored and report status 1; tick and delay words ignore the channel.
module multichannel_compare_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [2:0]  channel,
	input  logic [31:0] amount,
	input  logic [31:0] base_time,
	input  logic signed [31:0] adjust_amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  fire_mask,
	output logic        delay_done,
	output logic [31:0] now_time,
	output logic        status
);

	localparam int unsigned TW = mct_pkg::TIME_W;
	localparam int unsigned NC = mct_pkg::USER_CHANNELS;

	logic                 valid_s1;
	mct_pkg::req_type_t   req_s1;
	logic [2:0]           chan_s1;
	logic [TW-1:0]        amount_s1;
	logic [TW-1:0]        adj_s1;
	logic [TW-1:0]        diff_s1;
	logic [TW-1:0]        sum_s1;

	logic [TW-1:0]        tick_q;
	logic [TW-1:0]        delay_cmp_q;
	logic                 delay_active_q;

	logic                 out_valid_q;
	logic [7:0]           fire_mask_q;
	logic                 delay_done_q;
	logic [TW-1:0]        now_time_q;
	logic                 status_q;

	logic                 accept;
	logic                 go;
	logic                 is_tick;
	logic                 in_range;
	logic                 chan_cmd_req;
	logic                 bad_chan;
	logic                 done;
	logic [TW-1:0]        tick_next;
	mct_pkg::chan_cmd_t   cmd;
	logic [NC-1:0]        sel;
	logic [NC-1:0]        fire_vec;

	assign go       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// The reference-time sums do not depend on the counter and are formed on the way in.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= mct_pkg::req_type_t'(req_type);
			chan_s1   <= channel;
			amount_s1 <= amount;
			adj_s1    <= adjust_amount;
			diff_s1   <= amount - base_time;
			sum_s1    <= amount + base_time;
		end
	end

	assign tick_next    = tick_q + TW'(1);
	assign is_tick      = (req_s1 == mct_pkg::REQ_TICK);
	assign in_range     = ({1'b0, chan_s1} < 4'(NC));
	assign chan_cmd_req = (req_s1 != mct_pkg::REQ_TICK) && (req_s1 != mct_pkg::REQ_DELAY);
	assign bad_chan     = chan_cmd_req && !in_range;
	assign done         = is_tick && delay_active_q && (delay_cmp_q == tick_next);

	always_comb begin
		cmd          = '0;
		cmd.go       = go;
		cmd.tick     = is_tick;
		cmd.now_next = tick_next;
		cmd.adj      = adj_s1;
		unique case (req_s1) inside
			mct_pkg::REQ_PERIODIC, mct_pkg::REQ_ONESHOT: begin
				cmd.arm     = 1'b1;
				cmd.oneshot = (req_s1 == mct_pkg::REQ_ONESHOT);
				cmd.period  = amount_s1;
				cmd.compare = tick_q + amount_s1;
			end
			mct_pkg::REQ_REF_PLUS: begin
				cmd.arm     = 1'b1;
				cmd.oneshot = 1'b1;
				cmd.period  = tick_q + diff_s1;
				cmd.compare = {tick_q[TW-2:0], 1'b0} + diff_s1;
			end
			mct_pkg::REQ_REF_MINUS: begin
				cmd.arm     = 1'b1;
				cmd.oneshot = 1'b1;
				cmd.period  = sum_s1 - tick_q;
				cmd.compare = sum_s1;
			end
			mct_pkg::REQ_ADJUST: begin
				cmd.adjust = 1'b1;
			end
			mct_pkg::REQ_CANCEL: begin
				cmd.cancel = 1'b1;
			end
			default: begin
			end
		endcase
	end

	for (genvar c = 0; c < NC; c++) begin : g_chan
		assign sel[c] = chan_cmd_req && in_range && (chan_s1 == 3'(c));

		mct_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.sel    (sel[c]),
			.fire   (fire_vec[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q         <= '0;
			delay_cmp_q    <= '0;
			delay_active_q <= 1'b0;
		end else if (go) begin
			if (is_tick) begin
				tick_q <= tick_next;
				if (done) begin
					delay_active_q <= 1'b0;
				end
			end else if (req_s1 == mct_pkg::REQ_DELAY) begin
				delay_cmp_q    <= tick_q + amount_s1;
				delay_active_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			fire_mask_q  <= 8'(fire_vec);
			delay_done_q <= done;
			now_time_q   <= is_tick ? tick_next : tick_q;
			status_q     <= bad_chan;
		end
	end

	assign out_valid  = out_valid_q;
	assign fire_mask  = fire_mask_q;
	assign delay_done = delay_done_q;
	assign now_time   = now_time_q;
	assign status     = status_q;

endmodule

>>> hw/rtl/mct_checker.sv
// Port-level checks for the multichannel compare timer, bound to the top level.
module mct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  fire_mask,
	input logic        delay_done,
	input logic [31:0] now_time,
	input logic        status
);

	logic        seen_q;
	logic [31:0] last_now_q;
	logic        out_take;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_now_q <= '0;
		end else if (out_take) begin
			seen_q     <= 1'b1;
			last_now_q <= now_time;
		end
	end

	// A rejected command is never a tick, so nothing can fire with it.
	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (fire_mask == 8'd0) && !delay_done)
		else $error("status set together with a firing or delay report");

	a_absent_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fire_mask >> mct_pkg::USER_CHANNELS) == 8'd0))
		else $error("fire bit set for a channel that does not exist");

	// The counter moves by one on a tick and stays on a command; only ticks fire.
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && seen_q |->
			(now_time == last_now_q + 32'd1) ||
			((now_time == last_now_q) && (fire_mask == 8'd0) && !delay_done))
		else $error("counter step between results is wrong");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(now_time) && $stable(fire_mask))
		else $error("stalled result word changed");

endmodule

bind multichannel_compare_timer mct_checker u_mct_checker (.*);
